/* src/rgbnp_pkg.sv */
`default_nettype none

package rgbnp_pkg;

    localparam int CHAN_W     = 8;
    localparam int COL_W      = 13;
    localparam int MODE_W     = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;
    localparam int MEAN_SHIFT = 11;

    // output modes
    localparam logic [MODE_W-1:0] MODE_RGB     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GREY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BITONAL = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LEVEL = 2'd2;

    // byte slots of an rgb pixel
    localparam logic [1:0] BYTE_RED   = 2'd0;
    localparam logic [1:0] BYTE_GREEN = 2'd1;
    localparam logic [1:0] BYTE_BLUE  = 2'd2;

    // mean of three channels: sum * 683 >> 11 is exact for sums up to 765
    localparam logic [SUM_W-1:0] MEAN_RECIP = 10'd683;
    localparam logic [6:0]       CUT_OFFSET = 7'd13;

    localparam logic [COL_W-1:0] RESET_ROW_WIDTH = 13'd1;
    localparam logic [CHAN_W-1:0] RESET_MAX_LEVEL = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] mean;
        logic              black;
    } pix_info_t;

endpackage

`default_nettype wire

/* src/rgbnp_pixel_math.sv */
`default_nettype none

module rgbnp_pixel_math
    import rgbnp_pkg::*;
(
    input  wire logic [CHAN_W-1:0] red,
    input  wire logic [CHAN_W-1:0] green,
    input  wire logic [CHAN_W-1:0] blue,
    input  wire logic [CHAN_W-1:0] max_level,
    output pix_info_t              info
);

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [6:0]        half;
    logic [6:0]        cutoff;

    always_comb begin
        sum    = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
        prod   = PROD_W'(sum) * PROD_W'(MEAN_RECIP);
        half   = max_level[CHAN_W-1:1];
        cutoff = half - CUT_OFFSET;
        info.mean  = prod[MEAN_SHIFT +: CHAN_W];
        // a cutoff below zero would wrap, so that case is caught and every pixel is black
        info.black = (half < CUT_OFFSET) || (info.mean < CHAN_W'(cutoff));
    end

endmodule

`default_nettype wire

/* src/rgb_to_netpbm_raw_packer_unit.sv */
// an accepted pixel waits in the input register and reaches m_ through the result register
// rgb mode: three byte words per pixel, one per cycle from the result register unless stalled
// grey and bitonal modes take one pixel per cycle unless a word waits on m_ready; a bitonal
// pixel that closes no byte leaves no word; the single result register sets the rate
// reset: synchronous active-low aresetn clears column, bit accumulator and valids,
// and sets mode rgb, row width 1, max level 255
`default_nettype none

module rgb_to_netpbm_raw_packer_unit
    import rgbnp_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
)
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,

    // pixel input
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAN_W-1:0]     s_red,
    input  wire logic [CHAN_W-1:0]     s_green,
    input  wire logic [CHAN_W-1:0]     s_blue,

    // byte output
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CHAN_W-1:0]          m_out_byte,
    output logic                       m_last_of_pixel
);

    localparam int WCMP_W = (COL_W > $clog2(MAX_WIDTH + 1)) ? COL_W + 1
                                                             : $clog2(MAX_WIDTH + 1) + 1;

    // configuration registers
    logic [MODE_W-1:0] mode_reg;
    logic [COL_W-1:0]  row_width_reg;
    logic [CHAN_W-1:0] max_level_reg;

    // input register
    logic              pix_valid_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic [1:0]        byte_sel_reg;
    logic [1:0]        byte_sel_next;

    // row state
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic [CHAN_W-1:0] acc_reg;
    logic [CHAN_W-1:0] acc_next;

    // result register
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [CHAN_W-1:0] out_byte_reg;
    logic [CHAN_W-1:0] out_byte_next;
    logic              last_reg;
    logic              last_next;

    pix_info_t         info;

    logic              is_rgb;
    logic              is_grey;
    logic [COL_W-1:0]  width_use;
    logic              row_end;
    logic [2:0]        pos;
    logic [CHAN_W-1:0] acc_set;
    logic              bit_emit;
    logic              emit_want;
    logic              out_free;
    logic              pix_go;
    logic              pix_done;

    rgbnp_pixel_math u_math (
        .red       (red_reg),
        .green     (green_reg),
        .blue      (blue_reg),
        .max_level (max_level_reg),
        .info      (info)
    );

    always_comb begin
        is_rgb  = (mode_reg == MODE_RGB);
        is_grey = (mode_reg == MODE_GREY);

        // clamp the row width to 1..MAX_WIDTH
        if (row_width_reg == '0) begin
            width_use = COL_W'(1);
        end else if (WCMP_W'(row_width_reg) > WCMP_W'(MAX_WIDTH)) begin
            width_use = COL_W'(MAX_WIDTH);
        end else begin
            width_use = row_width_reg;
        end
        row_end = ((COL_W + 1)'(column_reg) + (COL_W + 1)'(1)) >= (COL_W + 1)'(width_use);

        // bitonal packing, msb first
        pos      = column_reg[2:0];
        acc_set  = acc_reg | (info.black ? (8'h80 >> pos) : 8'h00);
        bit_emit = (pos == 3'd7) || row_end;

        emit_want = is_rgb || is_grey || bit_emit;
        out_free  = !m_valid_reg || m_ready;
        pix_go    = pix_valid_reg && (out_free || !emit_want);
        pix_done  = pix_go && (!is_rgb || (byte_sel_reg == BYTE_BLUE));
        s_ready   = !pix_valid_reg || pix_done;

        // byte slot within an rgb pixel
        byte_sel_next = byte_sel_reg;
        if (pix_done) begin
            byte_sel_next = BYTE_RED;
        end else if (pix_go) begin
            byte_sel_next = byte_sel_reg + 2'd1;
        end

        // column advances in every mode, accumulator only in bitonal
        column_next = column_reg;
        acc_next    = acc_reg;
        if (pix_done) begin
            column_next = row_end ? '0 : column_reg + COL_W'(1);
            if (!is_rgb && !is_grey) begin
                acc_next = bit_emit ? '0 : acc_set;
            end
        end

        // result word
        out_byte_next = out_byte_reg;
        last_next     = last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (pix_go && emit_want) begin
            m_valid_next = 1'b1;
            if (is_rgb) begin
                last_next = (byte_sel_reg == BYTE_BLUE);
                case (byte_sel_reg)
                    BYTE_RED:   out_byte_next = red_reg;
                    BYTE_GREEN: out_byte_next = green_reg;
                    default:    out_byte_next = blue_reg;
                endcase
            end else begin
                last_next     = 1'b1;
                out_byte_next = is_grey ? info.mean : acc_set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RGB;
            row_width_reg <= RESET_ROW_WIDTH;
            max_level_reg <= RESET_MAX_LEVEL;
            pix_valid_reg <= 1'b0;
            byte_sel_reg  <= BYTE_RED;
            column_reg    <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // config writes, unknown indexes are dropped
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_MODE:      mode_reg      <= cfg_wr_data[MODE_W-1:0];
                    REG_ROW_WIDTH: row_width_reg <= cfg_wr_data;
                    REG_MAX_LEVEL: max_level_reg <= cfg_wr_data[CHAN_W-1:0];
                    default:       ;
                endcase
            end
            if (s_ready) begin
                pix_valid_reg <= s_valid;
            end
            byte_sel_reg <= byte_sel_next;
            column_reg   <= column_next;
            acc_reg      <= acc_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            red_reg   <= s_red;
            green_reg <= s_green;
            blue_reg  <= s_blue;
        end
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_last_of_pixel = last_reg;

    // byte slot never runs past blue
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_sel_reg == BYTE_RED || byte_sel_reg == BYTE_GREEN || byte_sel_reg == BYTE_BLUE)
        else $error("byte slot out of range");

    // a finished pixel restarts the slot count
    assert property (@(posedge aclk) disable iff (!aresetn)
        pix_done |=> byte_sel_reg == BYTE_RED)
        else $error("byte slot not restarted after pixel");

    // a non-final byte means its pixel is still held for the rest
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !last_reg) |-> pix_valid_reg)
        else $error("pixel dropped before its last byte");

endmodule

`default_nettype wire
